[design/pixel_hit_frame_merger_unit_assert.svh]
// ---------------------------------------------------------------------------
// Pixel hit frame merger assertion macros
// Shorthand for clocked implications used by the port checker.
// ---------------------------------------------------------------------------
`ifndef PIXEL_HIT_FRAME_MERGER_UNIT_ASSERT_SVH
`define PIXEL_HIT_FRAME_MERGER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk
`define PHFM_ASSERT_IMPLY(label, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk
`define PHFM_ASSERT_NEXT(label, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/phfm_pkg.sv]
// ---------------------------------------------------------------------------
// Pixel hit frame merger package
// Beat types, codes, register indexes and shared constants.
// ---------------------------------------------------------------------------
package phfm_pkg;

  // Default geometry
  localparam int SENSORS = 8;
  localparam int LINES   = 576;
  localparam int COLUMNS = 1152;

  // Storage organization
  localparam int WORD_BITS  = 32;
  localparam int EPOCH_BITS = 8;

  // Field and register widths
  localparam int TIMER_BITS  = 13;
  localparam int SPLIT_BITS  = 12;
  localparam int OVERLAP_BITS = 10;
  localparam int OFFSET_BITS = 11;
  localparam int CFG_DATA_BITS = 13;
  localparam int CFG_INDEX_BITS = 3;

  // Register reset values
  localparam logic [TIMER_BITS-1:0] MAX_TIMER_RESET  = 13'd8191;
  localparam logic [TIMER_BITS-1:0] CYCLE_TIME_RESET = 13'd1152;

  // Highest frame index that can be accepted
  localparam logic [2:0] LAST_FRAME = 3'd4;

  // Frame indexes used by the split-line and frame-0 merges
  localparam logic [2:0] FRAME_FIRST  = 3'd0;
  localparam logic [2:0] FRAME_UPPER  = 3'd1;
  localparam logic [2:0] FRAME_LOWER  = 3'd2;

  // Merge modes
  localparam logic [1:0] MODE_WINDOW = 2'd0;
  localparam logic [1:0] MODE_SPLIT  = 2'd1;
  localparam logic [1:0] MODE_FRAME0 = 2'd2;

  typedef enum logic [1:0] {
    REQ_EVENT  = 2'd0,
    REQ_HEADER = 2'd1,
    REQ_HIT    = 2'd2,
    REQ_MASK   = 2'd3
  } req_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MERGE_MODE  = 3'd0,
    REG_MIN_TIMER   = 3'd1,
    REG_MAX_TIMER   = 3'd2,
    REG_CYCLE_TIME  = 3'd3,
    REG_ROW_OVERLAP = 3'd4,
    REG_ROW_OFFSET  = 3'd5,
    REG_MASK_ENABLE = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_HOLD,
    ST_SPLIT
  } phfm_state_t;

  typedef enum logic [2:0] {
    SP_IDLE,
    SP_MUL,
    SP_ABS,
    SP_DIV,
    SP_ROUND,
    SP_DONE
  } split_state_t;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [2:0]            sensor_id;
    logic [9:0]            hit_line;
    logic [10:0]           hit_column;
    logic [2:0]            frame_number;
    logic [TIMER_BITS-1:0] frame_timer;
    logic                  mask_bit;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  kept_sensor;
    logic [9:0]  kept_line;
    logic [10:0] kept_column;
  } out_beat_t;

  typedef struct packed {
    logic                  start;
    logic [TIMER_BITS-1:0] timer;
  } split_req_t;

  typedef struct packed {
    logic                         done;
    logic signed [SPLIT_BITS-1:0] line;
  } split_rsp_t;

endpackage

[design/phfm_split.sv]
// ---------------------------------------------------------------------------
// Split line unit
// Computes round(LINES*(2*cycle-timer)/cycle) + offset, ties to even,
// saturated to the split line width, with a one-bit-per-cycle divider.
// ---------------------------------------------------------------------------
module phfm_split #(
  parameter int LINES = phfm_pkg::LINES
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic [phfm_pkg::TIMER_BITS-1:0]            cycle_time,
  input  logic signed [phfm_pkg::OFFSET_BITS-1:0]    row_offset,
  input  phfm_pkg::split_req_t                       req,
  output phfm_pkg::split_rsp_t                       rsp
);

  localparam int TB   = phfm_pkg::TIMER_BITS;
  localparam int SB   = phfm_pkg::SPLIT_BITS;
  localparam int LW   = $clog2(LINES + 1);
  localparam int NW   = LW + TB + 1;
  localparam int RW   = TB + 1;
  localparam int CNTW = $clog2(NW + 1);
  localparam logic signed [NW+2:0] SAT_HI = (NW+3)'(2 ** (SB - 1) - 1);
  localparam logic signed [NW+2:0] SAT_LO = -SAT_HI - (NW+3)'(1);

  phfm_pkg::split_state_t state, state_next;

  logic [TB-1:0]                  divisor;
  logic [TB-1:0]                  timer;
  logic signed [NW:0]             prod;
  logic                           neg;
  logic [NW-1:0]                  mag;
  logic [NW-1:0]                  quo;
  logic [RW-1:0]                  rem;
  logic [CNTW-1:0]                count;
  logic signed [SB-1:0]           line_out;

  logic signed [TB+1:0]           diff;
  logic [RW-1:0]                  rem_sh;
  logic                           rem_ge;
  logic                           round_up;
  logic [NW:0]                    quo_rnd;
  logic signed [NW+2:0]           quo_sgn;
  logic signed [NW+2:0]           split_raw;

  // Datapath terms
  always_comb begin
    diff     = $signed({1'b0, divisor, 1'b0}) - $signed({2'b00, timer});
    rem_sh   = {rem[RW-2:0], mag[NW-1]};
    rem_ge   = rem_sh >= {1'b0, divisor};
    round_up = ({rem, 1'b0} > {2'b00, divisor}) ||
               (({rem, 1'b0} == {2'b00, divisor}) && quo[0]);
    quo_rnd  = {1'b0, quo} + (NW+1)'(round_up);
    quo_sgn  = neg ? -$signed({2'b00, quo_rnd}) : $signed({2'b00, quo_rnd});
    split_raw = quo_sgn + (NW+3)'(row_offset);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= phfm_pkg::SP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and response
  always_comb begin
    state_next = state;
    rsp.done   = 1'b0;
    rsp.line   = line_out;
    unique case (state)
      phfm_pkg::SP_IDLE: begin
        if (req.start) state_next = phfm_pkg::SP_MUL;
      end
      phfm_pkg::SP_MUL:   state_next = phfm_pkg::SP_ABS;
      phfm_pkg::SP_ABS:   state_next = phfm_pkg::SP_DIV;
      phfm_pkg::SP_DIV: begin
        if (count == CNTW'(NW - 1)) state_next = phfm_pkg::SP_ROUND;
      end
      phfm_pkg::SP_ROUND: state_next = phfm_pkg::SP_DONE;
      phfm_pkg::SP_DONE: begin
        rsp.done   = 1'b1;
        state_next = phfm_pkg::SP_IDLE;
      end
      default: state_next = phfm_pkg::SP_IDLE;
    endcase
  end

  // Operand capture, multiply, magnitude, shift-subtract and rounding
  always_ff @(posedge clk) begin
    unique case (state)
      phfm_pkg::SP_IDLE: begin
        if (req.start) begin
          divisor <= (cycle_time == '0) ? TB'(1) : cycle_time;
          timer   <= req.timer;
        end
      end
      phfm_pkg::SP_MUL: begin
        prod <= $signed((NW+1)'(diff)) * $signed((NW+1)'(LINES));
      end
      phfm_pkg::SP_ABS: begin
        neg   <= prod[NW];
        mag   <= prod[NW] ? NW'(-prod) : NW'(prod);
        quo   <= '0;
        rem   <= '0;
        count <= '0;
      end
      phfm_pkg::SP_DIV: begin
        rem   <= rem_ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
        quo   <= {quo[NW-2:0], rem_ge};
        mag   <= {mag[NW-2:0], 1'b0};
        count <= count + CNTW'(1);
      end
      phfm_pkg::SP_ROUND: begin
        if (split_raw > SAT_HI) begin
          line_out <= SB'(SAT_HI);
        end else if (split_raw < SAT_LO) begin
          line_out <= SB'(SAT_LO);
        end else begin
          line_out <= SB'(split_raw);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[design/pixel_hit_frame_merger_unit.sv]
// Hit and mask write beats: the next beat waits for the read-modify-write state
// (and the hold state while the output stalls); a kept hit is registered to the
// output from there. Event starts and frame headers return to idle, but a header
// for frame 1 holds the input until the one-bit-per-cycle divider of the split
// line unit is done. After reset, and on every 256th event start, a clearing
// pass writes one word per cycle (2^19 words by default) while no beat is taken.
// ---------------------------------------------------------------------------
// Pixel hit frame merger
// Gates hits by frame, drops repeats within an event using an epoch-tagged
// seen bitmap, and filters hits flagged in the noisy pixel mask.
// ---------------------------------------------------------------------------
module pixel_hit_frame_merger_unit #(
  parameter int SENSORS = phfm_pkg::SENSORS,
  parameter int LINES   = phfm_pkg::LINES,
  parameter int COLUMNS = phfm_pkg::COLUMNS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  phfm_pkg::in_beat_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output phfm_pkg::out_beat_t                   out_data,
  input  logic                                  cfg_we,
  input  logic [phfm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [phfm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int TB    = phfm_pkg::TIMER_BITS;
  localparam int SB    = phfm_pkg::SPLIT_BITS;
  localparam int OVB   = phfm_pkg::OVERLAP_BITS;
  localparam int OFB   = phfm_pkg::OFFSET_BITS;
  localparam int WB    = phfm_pkg::WORD_BITS;
  localparam int EB    = phfm_pkg::EPOCH_BITS;
  localparam int SW    = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int LW    = $clog2(LINES + 1);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int BW    = $clog2(WB);
  localparam int AW    = SW + LW + CW;
  localparam int WAW   = AW - BW;
  localparam int DEPTH = 2 ** WAW;
  localparam int CMPW  = SB + 2;

  // Configuration registers
  logic [1:0]            merge_mode;
  logic [TB-1:0]         min_timer;
  logic [TB-1:0]         max_timer;
  logic [TB-1:0]         cycle_time;
  logic [OVB-1:0]        row_overlap;
  logic signed [OFB-1:0] row_offset;
  logic                  mask_enable;

  // Control state
  phfm_pkg::phfm_state_t state, state_next;
  logic                  frame_accepted;
  logic [2:0]            current_frame;
  logic signed [SB-1:0]  split_line;
  logic [EB-1:0]         epoch;
  logic [WAW-1:0]        clr_addr;
  logic                  clear_mask;

  // Item held for the read-modify-write
  phfm_pkg::in_beat_t    item;
  logic [WAW-1:0]        item_wa;
  logic [BW-1:0]         item_bit;
  logic                  item_ok;

  // Memories
  logic [EB+WB-1:0]      seen_mem [DEPTH];
  logic [WB-1:0]         mask_mem [DEPTH];
  logic [EB+WB-1:0]      seen_rd;
  logic [WB-1:0]         mask_rd;

  // Handshake and write controls
  logic                  in_acc;
  logic                  slot_free;
  logic                  out_load;
  logic                  seen_we;
  logic                  mask_we;
  logic                  seen_set;
  logic                  mask_upd;
  logic                  emit;
  logic [WAW-1:0]        mem_wa;
  logic [EB+WB-1:0]      seen_wd;
  logic [WB-1:0]         mask_wd;

  // Address and check terms
  logic [15:0]           s_ext;
  logic [15:0]           l_ext;
  logic [15:0]           c_ext;
  logic [AW-1:0]         in_addr;
  logic                  in_ok;
  logic                  window_ok;
  logic                  hdr_accept;
  logic [WB-1:0]         bit_mask;
  logic [WB-1:0]         seen_bits;
  logic                  already;
  logic                  noisy;
  logic signed [CMPW-1:0] line_s;
  logic signed [CMPW-1:0] split_lo;
  logic signed [CMPW-1:0] split_hi;
  logic                  split_drop;
  logic                  gate;

  phfm_pkg::split_req_t  split_req;
  phfm_pkg::split_rsp_t  split_rsp;

  phfm_split #(
    .LINES(LINES)
  ) u_split (
    .clk       (clk),
    .rst       (rst),
    .cycle_time(cycle_time),
    .row_offset(row_offset),
    .req       (split_req),
    .rsp       (split_rsp)
  );

  // Decode the incoming beat
  always_comb begin
    s_ext    = {13'd0, in_data.sensor_id};
    l_ext    = {6'd0, in_data.hit_line};
    c_ext    = {5'd0, in_data.hit_column};
    in_addr  = {s_ext[SW-1:0], l_ext[LW-1:0], c_ext[CW-1:0]};
    in_ok    = (s_ext < 16'(SENSORS)) && (l_ext <= 16'(LINES)) &&
               (c_ext <= 16'(COLUMNS));
    window_ok = (in_data.frame_number <= phfm_pkg::LAST_FRAME) &&
                (in_data.frame_timer > min_timer) &&
                (in_data.frame_timer < max_timer);
    priority if (merge_mode == phfm_pkg::MODE_SPLIT) begin
      hdr_accept = (in_data.frame_number == phfm_pkg::FRAME_UPPER) ||
                   (in_data.frame_number == phfm_pkg::FRAME_LOWER);
    end else if (merge_mode == phfm_pkg::MODE_FRAME0) begin
      hdr_accept = in_data.frame_number == phfm_pkg::FRAME_FIRST;
    end else begin
      hdr_accept = window_ok;
    end
  end

  // Gate and bitmap checks on the held item
  always_comb begin
    bit_mask   = WB'(1) << item_bit;
    seen_bits  = (seen_rd[EB+WB-1:WB] == epoch) ? seen_rd[WB-1:0] : '0;
    already    = |(seen_bits & bit_mask);
    noisy      = |(mask_rd & bit_mask);
    line_s     = $signed({{(CMPW-10){1'b0}}, item.hit_line});
    split_lo   = CMPW'(split_line) - $signed({{(CMPW-OVB){1'b0}}, row_overlap});
    split_hi   = CMPW'(split_line) + $signed({{(CMPW-OVB){1'b0}}, row_overlap});
    split_drop = (merge_mode == phfm_pkg::MODE_SPLIT) &&
                 (((current_frame == phfm_pkg::FRAME_UPPER) && (line_s < split_lo)) ||
                  ((current_frame == phfm_pkg::FRAME_LOWER) && (line_s > split_hi)));
    gate       = frame_accepted && item_ok && !split_drop;
    seen_set   = (item.req_type == phfm_pkg::REQ_HIT) && gate && !already;
    mask_upd   = (item.req_type == phfm_pkg::REQ_MASK) && item_ok;
    emit       = seen_set && !(mask_enable && noisy);
  end

  // Next state, handshake and memory write controls
  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    out_load        = 1'b0;
    seen_we         = 1'b0;
    mask_we         = 1'b0;
    split_req.start = 1'b0;
    split_req.timer = in_data.frame_timer;
    slot_free       = !out_valid || out_ready;
    in_acc          = 1'b0;
    unique case (state)
      phfm_pkg::ST_CLEAR: begin
        seen_we = 1'b1;
        mask_we = clear_mask;
        if (&clr_addr) state_next = phfm_pkg::ST_IDLE;
      end
      phfm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        in_acc   = in_valid;
        if (in_valid) begin
          unique case (in_data.req_type)
            phfm_pkg::REQ_EVENT: begin
              if (&epoch) state_next = phfm_pkg::ST_CLEAR;
            end
            phfm_pkg::REQ_HEADER: begin
              if (in_data.frame_number == phfm_pkg::FRAME_UPPER) begin
                split_req.start = 1'b1;
                state_next      = phfm_pkg::ST_SPLIT;
              end
            end
            phfm_pkg::REQ_HIT:  state_next = phfm_pkg::ST_RMW;
            phfm_pkg::REQ_MASK: state_next = phfm_pkg::ST_RMW;
            default: state_next = phfm_pkg::ST_IDLE;
          endcase
        end
      end
      phfm_pkg::ST_RMW: begin
        seen_we  = seen_set;
        mask_we  = mask_upd;
        out_load = emit && slot_free;
        state_next = (emit && !slot_free) ? phfm_pkg::ST_HOLD : phfm_pkg::ST_IDLE;
      end
      phfm_pkg::ST_HOLD: begin
        out_load = slot_free;
        if (slot_free) state_next = phfm_pkg::ST_IDLE;
      end
      phfm_pkg::ST_SPLIT: begin
        if (split_rsp.done) state_next = phfm_pkg::ST_IDLE;
      end
      default: state_next = phfm_pkg::ST_CLEAR;
    endcase
  end

  // Write data: zeros during a clearing pass, updated word otherwise
  always_comb begin
    if (state == phfm_pkg::ST_CLEAR) begin
      mem_wa  = clr_addr;
      seen_wd = '0;
      mask_wd = '0;
    end else begin
      mem_wa  = item_wa;
      seen_wd = {epoch, seen_bits | bit_mask};
      mask_wd = item.mask_bit ? (mask_rd | bit_mask) : (mask_rd & ~bit_mask);
    end
  end

  // Seen bitmap: epoch tag plus one word of bits
  always_ff @(posedge clk) begin
    if (seen_we) seen_mem[mem_wa] <= seen_wd;
    if (in_acc) seen_rd <= seen_mem[in_addr[AW-1:BW]];
  end

  // Noisy pixel mask
  always_ff @(posedge clk) begin
    if (mask_we) mask_mem[mem_wa] <= mask_wd;
    if (in_acc) mask_rd <= mask_mem[in_addr[AW-1:BW]];
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item     <= in_data;
      item_wa  <= in_addr[AW-1:BW];
      item_bit <= in_addr[BW-1:0];
      item_ok  <= in_ok;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.kept_sensor <= item.sensor_id;
      out_data.kept_line   <= item.hit_line;
      out_data.kept_column <= item.hit_column;
    end
  end

  // Control state, frame gating and epoch
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= phfm_pkg::ST_CLEAR;
      out_valid      <= 1'b0;
      frame_accepted <= 1'b0;
      current_frame  <= '0;
      split_line     <= '0;
      epoch          <= '0;
      clr_addr       <= '0;
      clear_mask     <= 1'b1;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == phfm_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + WAW'(1);
      end
      if (state == phfm_pkg::ST_SPLIT && split_rsp.done) begin
        split_line <= split_rsp.line;
      end
      if (in_acc && in_data.req_type == phfm_pkg::REQ_EVENT) begin
        frame_accepted <= 1'b0;
        epoch          <= epoch + EB'(1);
        if (&epoch) begin
          clr_addr   <= '0;
          clear_mask <= 1'b0;
        end
      end
      if (in_acc && in_data.req_type == phfm_pkg::REQ_HEADER) begin
        current_frame  <= in_data.frame_number;
        frame_accepted <= hdr_accept;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      merge_mode  <= phfm_pkg::MODE_WINDOW;
      min_timer   <= '0;
      max_timer   <= phfm_pkg::MAX_TIMER_RESET;
      cycle_time  <= phfm_pkg::CYCLE_TIME_RESET;
      row_overlap <= '0;
      row_offset  <= '0;
      mask_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        phfm_pkg::REG_MERGE_MODE:  merge_mode  <= cfg_data[1:0];
        phfm_pkg::REG_MIN_TIMER:   min_timer   <= cfg_data[TB-1:0];
        phfm_pkg::REG_MAX_TIMER:   max_timer   <= cfg_data[TB-1:0];
        phfm_pkg::REG_CYCLE_TIME:  cycle_time  <= cfg_data[TB-1:0];
        phfm_pkg::REG_ROW_OVERLAP: row_overlap <= cfg_data[OVB-1:0];
        phfm_pkg::REG_ROW_OFFSET:  row_offset  <= $signed(cfg_data[OFB-1:0]);
        phfm_pkg::REG_MASK_ENABLE: mask_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

[design/phfm_checker.sv]
// ---------------------------------------------------------------------------
// Pixel hit frame merger port checker
// Watches the top level ports for reset, sequencing and result rules.
// ---------------------------------------------------------------------------
`include "pixel_hit_frame_merger_unit_assert.svh"

module phfm_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input phfm_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input phfm_pkg::out_beat_t out_data
);

  // Reset leaves no result and starts the clearing pass
  `PHFM_ASSERT_NEXT(a_reset_quiet, 1'b0, rst, !out_valid && !in_ready, "reset state not quiet")

  // A stalled result holds its beat
  `PHFM_ASSERT_NEXT(a_out_hold, rst, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // A hit beat occupies the read-modify-write cycle
  `PHFM_ASSERT_NEXT(a_hit_busy, rst, in_valid && in_ready && in_data.req_type == phfm_pkg::REQ_HIT, !in_ready, "hit beat not given its write-back cycle")

  // Beats other than hits never produce a result
  `PHFM_ASSERT_IMPLY(a_nonhit_silent, rst, in_valid && in_ready && in_data.req_type != phfm_pkg::REQ_HIT && !out_valid, ##2 !out_valid, "result from a non-hit beat")

endmodule

bind pixel_hit_frame_merger_unit phfm_checker u_phfm_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

[dv/pixel_hit_frame_merger_unit_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Pixel hit frame merger testbench
// Drives event, header, hit and mask beats under random idling and a long
// output hold-off, predicts every kept hit from a local copy of the seen map,
// noisy mask, open frame and split line, and checks results in order.
// ---------------------------------------------------------------------------
module pixel_hit_frame_merger_unit_tb;
  import phfm_pkg::*;

  localparam int IDLE_PCT      = 22;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 12;
  localparam int PHASE_BEATS   = 100;
  localparam int POOL_DEPTH    = 16;
  localparam int TIMER_MAX     = 8191;
  // Mode value outside the named set; the block treats it as the window mode
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_MERGE_MODE;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  pixel_hit_frame_merger_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shared test state
  bit          steady = 1'b0;
  int unsigned hold_off_len = 0;
  int unsigned beats_sent = 0;
  int unsigned fail_count = 0;
  out_beat_t   expected_hits[$];
  in_beat_t    pixel_pool[$];

  // Local copy of configuration and block state
  logic [1:0]            mode_r = MODE_WINDOW;
  logic [TIMER_BITS-1:0] min_r = '0;
  logic [TIMER_BITS-1:0] max_r = MAX_TIMER_RESET;
  logic [TIMER_BITS-1:0] cycle_r = CYCLE_TIME_RESET;
  int                    overlap_r = 0;
  int                    offset_r = 0;
  logic                  mask_en_r = 1'b0;
  logic                  frame_open = 1'b0;
  logic [2:0]            cur_frame = '0;
  int                    split_r = 0;
  bit                    seen_px[int];
  bit                    noisy_px[int];

  function automatic void note_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%t %s", $realtime, msg);
  endfunction

  function automatic bit pixel_ok(logic [2:0] s, logic [9:0] l, logic [10:0] c);
    return s < SENSORS && l <= LINES && c <= COLUMNS;
  endfunction

  function automatic int pixel_key(logic [2:0] s, logic [9:0] l, logic [10:0] c);
    return (int'(s) * (LINES + 1) + int'(l)) * (COLUMNS + 1) + int'(c);
  endfunction

  // Split line: round half to even of LINES*(2*cycle-timer)/cycle, plus offset
  function automatic int split_for_timer(logic [TIMER_BITS-1:0] tm);
    longint d, t, n, mag, q, r, v;
    d = (cycle_r == 0) ? 1 : longint'(cycle_r);
    t = longint'(tm);
    n = longint'(LINES) * (2 * d - t);
    mag = (n < 0) ? -n : n;
    q = mag / d;
    r = mag % d;
    if (2 * r > d || (2 * r == d && (q % 2) != 0)) q++;
    v = ((n < 0) ? -q : q) + longint'(offset_r);
    if (v < -2048) v = -2048;
    if (v > 2047) v = 2047;
    return int'(v);
  endfunction

  // Advance the local state by one accepted beat; queue a kept hit if any
  function automatic void predict_kept_hit(in_beat_t b);
    int        key;
    int        line;
    out_beat_t hit;
    key = pixel_key(b.sensor_id, b.hit_line, b.hit_column);
    case (b.req_type)
      REQ_EVENT: begin
        seen_px.delete();
        frame_open = 1'b0;
      end
      REQ_HEADER: begin
        cur_frame = b.frame_number;
        if (b.frame_number == FRAME_UPPER) split_r = split_for_timer(b.frame_timer);
        if (mode_r == MODE_SPLIT) begin
          frame_open = b.frame_number == FRAME_UPPER || b.frame_number == FRAME_LOWER;
        end else if (mode_r == MODE_FRAME0) begin
          frame_open = b.frame_number == FRAME_FIRST;
        end else begin
          frame_open = b.frame_number <= LAST_FRAME && b.frame_timer > min_r &&
                       b.frame_timer < max_r;
        end
      end
      REQ_MASK: begin
        if (pixel_ok(b.sensor_id, b.hit_line, b.hit_column)) noisy_px[key] = b.mask_bit;
      end
      REQ_HIT: begin
        if (!frame_open || !pixel_ok(b.sensor_id, b.hit_line, b.hit_column)) return;
        if (mode_r == MODE_SPLIT) begin
          line = int'(b.hit_line);
          if (cur_frame == FRAME_UPPER && line < split_r - overlap_r) return;
          if (cur_frame == FRAME_LOWER && line > split_r + overlap_r) return;
        end
        if (seen_px.exists(key)) return;
        seen_px[key] = 1'b1;
        if (mask_en_r && noisy_px.exists(key) && noisy_px[key]) return;
        hit.kept_sensor = b.sensor_id;
        hit.kept_line   = b.hit_line;
        hit.kept_column = b.hit_column;
        expected_hits.push_back(hit);
      end
    endcase
  endfunction

  // Beat builders: fields a beat does not use carry random values
  function automatic in_beat_t rand_beat();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_beat_t)-1:0];
  endfunction

  function automatic in_beat_t mk_event();
    in_beat_t b;
    b = rand_beat();
    b.req_type = REQ_EVENT;
    return b;
  endfunction

  function automatic in_beat_t mk_header(logic [2:0] fr, logic [TIMER_BITS-1:0] tm);
    in_beat_t b;
    b = rand_beat();
    b.req_type     = REQ_HEADER;
    b.frame_number = fr;
    b.frame_timer  = tm;
    return b;
  endfunction

  function automatic in_beat_t mk_hit(logic [2:0] s, logic [9:0] l, logic [10:0] c);
    in_beat_t b;
    b = rand_beat();
    b.req_type   = REQ_HIT;
    b.sensor_id  = s;
    b.hit_line   = l;
    b.hit_column = c;
    return b;
  endfunction

  function automatic in_beat_t mk_mask(logic [2:0] s, logic [9:0] l, logic [10:0] c,
                                       logic flag);
    in_beat_t b;
    b = mk_hit(s, l, c);
    b.req_type = REQ_MASK;
    b.mask_bit = flag;
    return b;
  endfunction

  // Offer one beat, with random idle cycles ahead of it, and hold until taken
  task automatic send_beat(in_beat_t b);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    predict_kept_hit(b);
  endtask

  // Drop valid, wait for every expected hit, then let the block go quiet
  task automatic settle();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_hits.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_hits.size() != 0) begin
      note_fail($sformatf("%0d expected hits never came out", expected_hits.size()));
      expected_hits.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MERGE_MODE:  mode_r = val[1:0];
      REG_MIN_TIMER:   min_r = val[TIMER_BITS-1:0];
      REG_MAX_TIMER:   max_r = val[TIMER_BITS-1:0];
      REG_CYCLE_TIME:  cycle_r = val[TIMER_BITS-1:0];
      REG_ROW_OVERLAP: overlap_r = int'(val[OVERLAP_BITS-1:0]);
      REG_ROW_OFFSET:  offset_r = int'($signed(val[OFFSET_BITS-1:0]));
      REG_MASK_ENABLE: mask_en_r = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [1:0] mode, logic [TIMER_BITS-1:0] tmin,
                               logic [TIMER_BITS-1:0] tmax, logic [TIMER_BITS-1:0] cyc,
                               logic [OVERLAP_BITS-1:0] ovl, logic [OFFSET_BITS-1:0] ofs,
                               logic men);
    write_reg(REG_MERGE_MODE, mode);
    write_reg(REG_MIN_TIMER, tmin);
    write_reg(REG_MAX_TIMER, tmax);
    write_reg(REG_CYCLE_TIME, cyc);
    write_reg(REG_ROW_OVERLAP, ovl);
    write_reg(REG_ROW_OFFSET, ofs);
    write_reg(REG_MASK_ENABLE, men);
  endtask

  // Timer near the window bounds, inside the split range, or anywhere
  function automatic logic [TIMER_BITS-1:0] pick_timer();
    int t;
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: t = min_r;
          1: t = min_r + 13'd1;
          2: t = max_r - 13'd1;
          default: t = max_r;
        endcase
      end
      1: begin
        t = $urandom_range(2 * cycle_r, cycle_r);
        if (t > TIMER_MAX) t = TIMER_MAX;
      end
      default: t = $urandom_range(TIMER_MAX);
    endcase
    return t[TIMER_BITS-1:0];
  endfunction

  // Hit from the recent pixel pool, a raw address, a line near the split, or any valid pixel
  function automatic in_beat_t pick_hit();
    in_beat_t b;
    int       r;
    int       line;
    int       jitter;
    r = $urandom_range(99);
    if (r < 30 && pixel_pool.size() != 0) begin
      b = pixel_pool[$urandom_range(pixel_pool.size() - 1)];
      return mk_hit(b.sensor_id, b.hit_line, b.hit_column);
    end
    if (r < 38) begin
      b = rand_beat();
      b.req_type = REQ_HIT;
    end else begin
      line = $urandom_range(LINES);
      if (r < 60) begin
        jitter = $urandom_range(4);
        line = ($urandom_range(1) ? split_r + overlap_r : split_r - overlap_r) - 2 + jitter;
        if (line < 0) line = 0;
        if (line > LINES) line = LINES;
      end
      b = mk_hit(3'($urandom_range(SENSORS - 1)), 10'(line),
                 11'($urandom_range(COLUMNS)));
    end
    pixel_pool.push_back(b);
    if (pixel_pool.size() > POOL_DEPTH) void'(pixel_pool.pop_front());
    return b;
  endfunction

  function automatic in_beat_t pick_mask();
    in_beat_t b;
    if ($urandom_range(99) < 70 && pixel_pool.size() != 0) begin
      b = pixel_pool[$urandom_range(pixel_pool.size() - 1)];
      return mk_mask(b.sensor_id, b.hit_line, b.hit_column, 1'($urandom_range(1)));
    end
    b = rand_beat();
    b.req_type = REQ_MASK;
    return b;
  endfunction

  // One well-formed event: start, a few frame headers, hits and mask writes
  task automatic send_random_event();
    int unsigned nframes;
    int unsigned nhits;
    logic [2:0]  fr;
    send_beat(mk_event());
    nframes = $urandom_range(4, 1);
    for (int k = 0; k < nframes; k++) begin
      fr = ($urandom_range(4) == 0) ? 3'($urandom_range(7)) : 3'(k);
      send_beat(mk_header(fr, pick_timer()));
      nhits = $urandom_range(8);
      for (int h = 0; h < nhits; h++) begin
        if ($urandom_range(99) < 8) send_beat(pick_mask());
        else send_beat(pick_hit());
      end
    end
  endtask

  // Check each result beat against the oldest expected hit
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        note_fail($sformatf("unexpected hit: sensor %0d line %0d column %0d",
                            out_data.kept_sensor, out_data.kept_line,
                            out_data.kept_column));
      end else begin
        want = expected_hits.pop_front();
        if (out_data.kept_sensor !== want.kept_sensor ||
            out_data.kept_line !== want.kept_line ||
            out_data.kept_column !== want.kept_column) begin
          note_fail($sformatf("hit mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                              want.kept_sensor, want.kept_line, want.kept_column,
                              out_data.kept_sensor, out_data.kept_line,
                              out_data.kept_column));
        end
      end
    end
  end

  // Result side ready: random idling, or a counted hold-off when requested
  initial begin : rx_side
    int unsigned hold;
    forever begin
      @(posedge clk);
      if (hold_off_len != 0) begin
        hold = hold_off_len;
        hold_off_len = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Window mode: bounds are exclusive, frames above four never open
  task automatic test_window_gating();
    settle();
    apply_setting(MODE_WINDOW, 13'd100, 13'd200, CYCLE_TIME_RESET, '0, '0, 1'b0);
    send_beat(mk_hit(3'd1, 10'd1, 11'd1));
    send_beat(mk_event());
    send_beat(mk_header(FRAME_FIRST, 13'd100));
    send_beat(mk_hit(3'd1, 10'd1, 11'd1));
    send_beat(mk_header(3'd3, 13'd101));
    send_beat(mk_hit(3'd0, 10'd0, 11'd0));
    send_beat(mk_hit(3'd7, 10'd576, 11'd1152));
    send_beat(mk_hit(3'd7, 10'd576, 11'd1152));
    send_beat(mk_hit(3'd2, 10'd577, 11'd1152));
    send_beat(mk_hit(3'd2, 10'd576, 11'd1153));
    send_beat(mk_header(3'd5, 13'd150));
    send_beat(mk_hit(3'd3, 10'd3, 11'd3));
    send_beat(mk_header(FRAME_FIRST, 13'd200));
    send_beat(mk_hit(3'd3, 10'd4, 11'd3));
  endtask

  // Split mode: stale line from reset, then a tie that rounds to even
  task automatic test_split_merge();
    settle();
    apply_setting(MODE_SPLIT, 13'd100, 13'd200, CYCLE_TIME_RESET, '0, '0, 1'b0);
    send_beat(mk_event());
    send_beat(mk_header(FRAME_LOWER, 13'd0));
    send_beat(mk_hit(3'd0, 10'd0, 11'd5));
    send_beat(mk_hit(3'd0, 10'd1, 11'd5));
    send_beat(mk_header(FRAME_UPPER, 13'd2299));
    send_beat(mk_hit(3'd0, 10'd1, 11'd6));
    send_beat(mk_hit(3'd0, 10'd2, 11'd6));
    send_beat(mk_header(FRAME_LOWER, 13'd0));
    send_beat(mk_hit(3'd0, 10'd3, 11'd7));
    send_beat(mk_hit(3'd0, 10'd2, 11'd7));
  endtask

  task automatic test_frame0_only();
    settle();
    apply_setting(MODE_FRAME0, 13'd100, 13'd200, CYCLE_TIME_RESET, '0, '0, 1'b0);
    send_beat(mk_event());
    send_beat(mk_header(FRAME_UPPER, 13'd150));
    send_beat(mk_hit(3'd1, 10'd2, 11'd3));
    send_beat(mk_header(FRAME_FIRST, 13'd8191));
    send_beat(mk_hit(3'd1, 10'd2, 11'd3));
  endtask

  // Masked hit still marks the pixel seen; a cleared mask frees it next event
  task automatic test_noisy_mask();
    settle();
    apply_setting(MODE_FRAME0, '0, MAX_TIMER_RESET, CYCLE_TIME_RESET, '0, '0, 1'b1);
    send_beat(mk_mask(3'd4, 10'd10, 11'd10, 1'b1));
    send_beat(mk_mask(3'd4, 10'd577, 11'd10, 1'b1));
    send_beat(mk_event());
    send_beat(mk_header(FRAME_FIRST, 13'd0));
    send_beat(mk_hit(3'd4, 10'd10, 11'd10));
    send_beat(mk_mask(3'd4, 10'd10, 11'd10, 1'b0));
    send_beat(mk_hit(3'd4, 10'd10, 11'd10));
    send_beat(mk_event());
    send_beat(mk_header(FRAME_FIRST, 13'd0));
    send_beat(mk_hit(3'd4, 10'd10, 11'd10));
  endtask

  // Hold the result side while hits keep coming, then pause until drained
  task automatic test_backpressure();
    settle();
    apply_setting(MODE_FRAME0, '0, MAX_TIMER_RESET, CYCLE_TIME_RESET, '0, '0, 1'b0);
    send_beat(mk_event());
    send_beat(mk_header(FRAME_FIRST, 13'd0));
    hold_off_len = HOLD_CYCLES;
    for (int i = 0; i < 60; i++) begin
      send_beat(mk_hit(3'(i % SENSORS), 10'(i), 11'(3 * i)));
    end
    settle();
  endtask

  // Random events over a series of settings, extremes first
  task automatic test_random_traffic();
    int unsigned first;
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: apply_setting(MODE_WINDOW, '0, MAX_TIMER_RESET, CYCLE_TIME_RESET, '0, '0, 1'b0);
        1: apply_setting(MODE_SPLIT, '0, MAX_TIMER_RESET, CYCLE_TIME_RESET, '0, '0, 1'b0);
        2: apply_setting(MODE_SPLIT, '0, MAX_TIMER_RESET, CYCLE_TIME_RESET, 10'd576,
                         11'(-576), 1'b1);
        3: apply_setting(MODE_SPLIT, '0, MAX_TIMER_RESET, 13'd1, 10'd1023, 11'd1023, 1'b0);
        4: apply_setting(MODE_WINDOW, 13'd8191, 13'd0, 13'd8191, '0, 11'(-1024), 1'b1);
        5: apply_setting(MODE_FRAME0, 13'd1000, 13'd3000, 13'd0, 10'd3, 11'd576, 1'b1);
        6: apply_setting(MODE_SPARE, 13'd1000, 13'd3000, 13'd2000, 10'd10, 11'd5, 1'b0);
        default: apply_setting(2'($urandom_range(3)), 13'($urandom), 13'($urandom),
                               13'($urandom), 10'($urandom), 11'($urandom),
                               1'($urandom_range(1)));
      endcase
      steady = (p == 8);
      first = beats_sent;
      while (beats_sent - first < PHASE_BEATS) begin
        if ($urandom_range(99) < 15) send_beat(rand_beat());
        else send_random_event();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_window_gating();
    test_split_merge();
    test_frame0_only();
    test_noisy_mask();
    test_backpressure();
    test_random_traffic();
    settle();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Covers the clearing pass after reset plus the whole run several times over
  initial begin
    #25ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
